>>> hw/rtl/rmcgga_pkg.sv
// ----------------------------------------------------------------------------
// rmcgga_pkg
// Shared types, character codes and fixed-point constants of the RMC/GGA
// line parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rmcgga_pkg;

  // Field length limits
  localparam int unsigned COORD_FIELD_CHARS      = 15;
  localparam int unsigned SATS_FIELD_CHARS       = 7;
  localparam int unsigned HDOP_FIELD_CHARS       = 15;
  localparam int unsigned MINUTE_FRACTION_DIGITS = 5;
  localparam int unsigned COMMA_MAX              = 15;
  localparam int unsigned CIF_MAX                = 31;

  function automatic longint unsigned pow10(input int unsigned n);
    longint unsigned v;
    v = 64'd1;
    for (int unsigned i = 0; i < n; i++) begin
      v = v * 64'd10;
    end
    return v;
  endfunction

  // Minutes are held in units of 10^-F minute; the running quotient holds
  // floor(minutes * 10^(7-F) / 60), i.e. the minute share in 1e-7 degree.
  localparam longint unsigned MIN_CAP   = 64'd999999999999;
  localparam longint unsigned MIN_SCALE = pow10(7 - MINUTE_FRACTION_DIGITS);
  localparam longint unsigned QCAP      = MIN_CAP * MIN_SCALE / 60;
  localparam longint unsigned RCAP      = MIN_CAP * MIN_SCALE % 60;
  localparam int unsigned     QW        = $clog2(QCAP + 64'd1);
  localparam int unsigned     QW4       = QW + 4;
  localparam int unsigned     MAGW      = QW + 1;
  localparam int unsigned     MW        = 40;
  localparam int unsigned     MW4       = MW + 4;
  localparam int unsigned     XW        = 27;

  localparam logic [QW-1:0] QCAP_V    = QW'(QCAP);
  localparam logic [5:0]    RCAP_V    = 6'(RCAP);
  localparam logic [MW-1:0] MIN_CAP_V = MW'(MIN_CAP);
  localparam logic [MW-1:0] MIN_CAP10 = MW'(MIN_CAP / 10);

  // x / 60 as (x * RECIP_60) >> RECIP_SHIFT, exact for x below 2^XW
  localparam logic [27:0] RECIP_60    = 28'd143165577;
  localparam int unsigned RECIP_SHIFT = 33;
  localparam int unsigned PRODW       = XW + 28;

  localparam logic [30:0] LAT_CAP      = 31'd999999999;
  localparam logic [34:0] LON_CAP      = 35'd9999999999;
  localparam logic [13:0] HDOP_DEFAULT = 14'd999;
  localparam logic [13:0] HDOP_CAP     = 14'd9999;
  localparam logic [13:0] HDOP_CAP10   = 14'd999;

  // Character codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_1      = 8'h31;
  localparam logic [7:0] CH_2      = 8'h32;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_W      = 8'h57;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_RMC  = 2'd1,
    KIND_GGA  = 2'd2,
    KIND_PEND = 2'd3
  } kind_t;

  // One finished line, handed from the parser to the output stage
  typedef struct packed {
    kind_t          kind;
    logic           fix;
    logic           south;
    logic           west;
    logic [29:0]    lat_ds;
    logic [QW-1:0]  lat_q;
    logic [33:0]    lon_ds;
    logic [QW-1:0]  lon_q;
    logic [13:0]    hdop;
    logic [7:0]     sats;
  } rec_t;

  // Digit times a power of ten, j in 0..7
  function automatic logic [XW-1:0] digit_pow10(input logic [3:0] d, input logic [2:0] j);
    logic [XW-1:0] p;
    unique case (j)
      3'd0: p = XW'(1);
      3'd1: p = XW'(10);
      3'd2: p = XW'(100);
      3'd3: p = XW'(1000);
      3'd4: p = XW'(10000);
      3'd5: p = XW'(100000);
      3'd6: p = XW'(1000000);
      3'd7: p = XW'(10000000);
      default: p = XW'(0);
    endcase
    return XW'(XW'(d) * p);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rmcgga_front.sv
// ----------------------------------------------------------------------------
// rmcgga_front
// Character parser: recognizes the sentence, counts commas and accumulates
// the fields; emits one record per line.
// ----------------------------------------------------------------------------
`default_nettype none

module rmcgga_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        char_byte,
  input  logic              line_end,
  output logic              push,
  output rmcgga_pkg::rec_t  rec
);

  localparam int unsigned QW  = rmcgga_pkg::QW;
  localparam int unsigned QW4 = rmcgga_pkg::QW4;
  localparam int unsigned MW  = rmcgga_pkg::MW;
  localparam int unsigned MW4 = rmcgga_pkg::MW4;
  localparam int unsigned XW  = rmcgga_pkg::XW;
  localparam int unsigned F   = rmcgga_pkg::MINUTE_FRACTION_DIGITS;

  logic [2:0]          pos_r, pos_nxt;
  rmcgga_pkg::kind_t   kind_r, kind_nxt;
  logic [3:0]          comma_r, comma_nxt;
  logic [4:0]          cif_r, cif_nxt;
  logic [7:0]          status_r, status_nxt;
  logic [1:0]          hemi_r, hemi_nxt;
  logic [29:0]         lat_ds_r, lat_ds_nxt;
  logic [MW-1:0]       lat_min_r, lat_min_nxt;
  logic [QW-1:0]       lat_q_r, lat_q_nxt;
  logic [5:0]          lat_rem_r, lat_rem_nxt;
  logic [33:0]         lon_ds_r, lon_ds_nxt;
  logic [MW-1:0]       lon_min_r, lon_min_nxt;
  logic [QW-1:0]       lon_q_r, lon_q_nxt;
  logic [5:0]          lon_rem_r, lon_rem_nxt;
  logic [7:0]          sats_r, sats_nxt;
  logic [13:0]         hdop_r, hdop_nxt;
  logic                dps_r, dps_nxt;
  logic [2:0]          frac_r, frac_nxt;

  logic                dig, is_comma, first, kind12, is_lat, is_lon, coord_on, in_deg;
  logic                coord_dig_int, coord_dig_fr, hd_on, coords_ok;
  logic [3:0]          d, lat_c;
  logic [33:0]         ds_sel;
  logic [37:0]         ds_step;
  logic [MW-1:0]       min_sel, min_new;
  logic [QW-1:0]       q_sel, q_new;
  logic [5:0]          rem_sel, rem_new;
  logic [MW4-1:0]      min_int;
  logic [MW:0]         min_fr;
  logic [XW-1:0]       xv, rn_full;
  logic [rmcgga_pkg::PRODW-1:0] prod;
  logic [21:0]         qd;
  logic [QW4-1:0]      q_int;
  logic [QW:0]         q_fr;
  logic                clamp;
  logic [14:0]         hd_t;
  logic [2:0]          fr_j;
  rmcgga_pkg::kind_t   k_out;

  always_comb begin
    dig      = (char_byte >= rmcgga_pkg::CH_0) && (char_byte <= rmcgga_pkg::CH_9);
    d        = dig ? 4'(char_byte - rmcgga_pkg::CH_0) : 4'd0;
    is_comma = (char_byte == rmcgga_pkg::CH_COMMA);
    first    = (cif_r == 5'd0);

    // Sentence recognition on the first six characters
    kind_nxt = kind_r;
    priority if (pos_r == 3'd0) begin
      kind_nxt = (char_byte == rmcgga_pkg::CH_DOLLAR) ? rmcgga_pkg::KIND_PEND
                                                      : rmcgga_pkg::KIND_NONE;
    end else if (pos_r == 3'd3 && kind_r == rmcgga_pkg::KIND_PEND) begin
      kind_nxt = (char_byte == rmcgga_pkg::CH_R) ? rmcgga_pkg::KIND_RMC :
                 (char_byte == rmcgga_pkg::CH_G) ? rmcgga_pkg::KIND_GGA :
                                                   rmcgga_pkg::KIND_NONE;
    end else if (pos_r == 3'd4) begin
      if ((kind_r == rmcgga_pkg::KIND_RMC && char_byte != rmcgga_pkg::CH_M) ||
          (kind_r == rmcgga_pkg::KIND_GGA && char_byte != rmcgga_pkg::CH_G)) begin
        kind_nxt = rmcgga_pkg::KIND_NONE;
      end
    end else if (pos_r == 3'd5) begin
      if ((kind_r == rmcgga_pkg::KIND_RMC && char_byte != rmcgga_pkg::CH_C) ||
          (kind_r == rmcgga_pkg::KIND_GGA && char_byte != rmcgga_pkg::CH_A)) begin
        kind_nxt = rmcgga_pkg::KIND_NONE;
      end
    end else begin
      kind_nxt = kind_r;
    end
    pos_nxt = (pos_r < 3'd7) ? pos_r + 3'd1 : pos_r;

    kind12 = (kind_nxt == rmcgga_pkg::KIND_RMC) || (kind_nxt == rmcgga_pkg::KIND_GGA);
    lat_c  = (kind_nxt == rmcgga_pkg::KIND_RMC) ? 4'd3 : 4'd2;

    comma_nxt   = comma_r;
    cif_nxt     = cif_r;
    status_nxt  = status_r;
    hemi_nxt    = hemi_r;
    lat_ds_nxt  = lat_ds_r;
    lat_min_nxt = lat_min_r;
    lat_q_nxt   = lat_q_r;
    lat_rem_nxt = lat_rem_r;
    lon_ds_nxt  = lon_ds_r;
    lon_min_nxt = lon_min_r;
    lon_q_nxt   = lon_q_r;
    lon_rem_nxt = lon_rem_r;
    sats_nxt    = sats_r;
    hdop_nxt    = hdop_r;
    dps_nxt     = dps_r;
    frac_nxt    = frac_r;

    // Shared coordinate unit: only one coordinate field is open at a time
    is_lat   = !is_comma && kind12 && (comma_r == lat_c);
    is_lon   = !is_comma && kind12 && (comma_r == lat_c + 4'd2);
    coord_on = (is_lat || is_lon) && (cif_r < 5'(rmcgga_pkg::COORD_FIELD_CHARS));
    in_deg   = cif_r < (is_lon ? 5'd3 : 5'd2);
    ds_sel   = is_lon ? lon_ds_r : {4'd0, lat_ds_r};
    min_sel  = is_lon ? lon_min_r : lat_min_r;
    q_sel    = is_lon ? lon_q_r : lat_q_r;
    rem_sel  = is_lon ? lon_rem_r : lat_rem_r;

    ds_step = ({4'd0, ds_sel} << 3) + ({4'd0, ds_sel} << 1)
            + 38'(rmcgga_pkg::digit_pow10(d, 3'd7));

    coord_dig_int = coord_on && !in_deg && dig && !dps_r;
    coord_dig_fr  = coord_on && !in_deg && dig && dps_r && (frac_r < 3'(F));
    fr_j          = 3'(F - 1) - frac_r;

    min_int = (MW4'(min_sel) << 3) + (MW4'(min_sel) << 1)
            + MW4'(rmcgga_pkg::digit_pow10(d, 3'(F)));
    min_fr  = {1'b0, min_sel} + (MW + 1)'(rmcgga_pkg::digit_pow10(d, fr_j));

    // Running quotient and remainder of minutes * 10^(7-F) by 60
    xv = coord_dig_int
       ? XW'((XW'(rem_sel) << 3) + (XW'(rem_sel) << 1) + rmcgga_pkg::digit_pow10(d, 3'd7))
       : XW'(XW'(rem_sel) + rmcgga_pkg::digit_pow10(d, 3'd6 - frac_r));
    prod    = rmcgga_pkg::PRODW'(xv) * rmcgga_pkg::PRODW'(rmcgga_pkg::RECIP_60);
    qd      = prod[rmcgga_pkg::RECIP_SHIFT +: 22];
    rn_full = xv - (XW'(qd) << 6) + (XW'(qd) << 2);
    q_int   = (QW4'(q_sel) << 3) + (QW4'(q_sel) << 1) + QW4'(qd);
    q_fr    = {1'b0, q_sel} + (QW + 1)'(qd);

    clamp   = 1'b0;
    min_new = min_sel;
    q_new   = q_sel;
    rem_new = rem_sel;
    if (coord_dig_int) begin
      if (min_sel > rmcgga_pkg::MIN_CAP10 || min_int > MW4'(rmcgga_pkg::MIN_CAP_V)) begin
        clamp = 1'b1;
      end else begin
        min_new = MW'(min_int);
        q_new   = QW'(q_int);
        rem_new = 6'(rn_full);
      end
    end else if (coord_dig_fr) begin
      if (min_fr > (MW + 1)'(rmcgga_pkg::MIN_CAP_V)) begin
        clamp = 1'b1;
      end else begin
        min_new = MW'(min_fr);
        q_new   = QW'(q_fr);
        rem_new = 6'(rn_full);
      end
    end
    if (clamp) begin
      min_new = rmcgga_pkg::MIN_CAP_V;
      q_new   = rmcgga_pkg::QCAP_V;
      rem_new = rmcgga_pkg::RCAP_V;
    end

    // HDOP in tenths
    hd_on = !is_comma && (kind_nxt == rmcgga_pkg::KIND_GGA) && (comma_r == 4'd8) &&
            (cif_r < 5'(rmcgga_pkg::HDOP_FIELD_CHARS));
    hd_t  = {1'b0, hdop_r};
    if (!dps_r) begin
      hd_t = (hdop_r > rmcgga_pkg::HDOP_CAP10) ? {1'b0, rmcgga_pkg::HDOP_CAP}
           : ({1'b0, hdop_r} << 3) + ({1'b0, hdop_r} << 1) + 15'(d) * 15'd10;
    end else begin
      hd_t = {1'b0, hdop_r} + 15'(d);
    end
    if (hd_t > {1'b0, rmcgga_pkg::HDOP_CAP}) begin
      hd_t = {1'b0, rmcgga_pkg::HDOP_CAP};
    end

    if (is_comma) begin
      if (comma_r < 4'(rmcgga_pkg::COMMA_MAX)) begin
        comma_nxt = comma_r + 4'd1;
        cif_nxt   = 5'd0;
        dps_nxt   = 1'b0;
        frac_nxt  = 3'd0;
        if (comma_nxt == 4'd6 && kind_nxt == rmcgga_pkg::KIND_GGA) begin
          status_nxt = 8'd0;
        end
      end
    end else begin
      if (comma_r == 4'd2 && first) begin
        status_nxt = char_byte;
      end
      if (kind_nxt == rmcgga_pkg::KIND_GGA && comma_r == 4'd6 && first) begin
        status_nxt = char_byte;
      end
      if (kind12 && first && comma_r == lat_c + 4'd1 && char_byte == rmcgga_pkg::CH_S) begin
        hemi_nxt[0] = 1'b1;
      end
      if (kind12 && first && comma_r == lat_c + 4'd3 && char_byte == rmcgga_pkg::CH_W) begin
        hemi_nxt[1] = 1'b1;
      end
      if (coord_on) begin
        if (in_deg) begin
          if (dig) begin
            if (is_lon) lon_ds_nxt = 34'(ds_step);
            else        lat_ds_nxt = 30'(ds_step);
          end
        end else if (char_byte == rmcgga_pkg::CH_DOT) begin
          dps_nxt = 1'b1;
        end else begin
          if (coord_dig_fr) frac_nxt = frac_r + 3'd1;
          if (is_lon) begin
            lon_min_nxt = min_new;
            lon_q_nxt   = q_new;
            lon_rem_nxt = rem_new;
          end else begin
            lat_min_nxt = min_new;
            lat_q_nxt   = q_new;
            lat_rem_nxt = rem_new;
          end
        end
      end
      if (kind_nxt == rmcgga_pkg::KIND_GGA && comma_r == 4'd7 && dig &&
          cif_r < 5'(rmcgga_pkg::SATS_FIELD_CHARS)) begin
        sats_nxt = 8'(({1'b0, sats_r} << 3) + ({1'b0, sats_r} << 1) + 9'(d));
      end
      if (hd_on) begin
        if (char_byte == rmcgga_pkg::CH_DOT) begin
          dps_nxt = 1'b1;
        end else if (dig) begin
          if (!dps_r || frac_r == 3'd0) begin
            hdop_nxt = 14'(hd_t);
            if (dps_r) frac_nxt = 3'd1;
          end
        end
      end
      if (cif_r < 5'(rmcgga_pkg::CIF_MAX)) cif_nxt = cif_r + 5'd1;
    end

    // Line-end record, built from the updated state
    k_out     = (pos_r >= 3'd5 && kind12) ? kind_nxt : rmcgga_pkg::KIND_NONE;
    coords_ok = (k_out != rmcgga_pkg::KIND_NONE) && (comma_nxt >= lat_c + 4'd3);
    rec.kind  = k_out;
    rec.fix   = ((k_out == rmcgga_pkg::KIND_RMC) && comma_nxt >= 4'd2 &&
                 status_nxt == rmcgga_pkg::CH_A) ||
                ((k_out == rmcgga_pkg::KIND_GGA) && comma_nxt >= 4'd6 &&
                 (status_nxt == rmcgga_pkg::CH_1 || status_nxt == rmcgga_pkg::CH_2));
    rec.south  = coords_ok && hemi_nxt[0];
    rec.west   = coords_ok && hemi_nxt[1];
    rec.lat_ds = coords_ok ? lat_ds_nxt : 30'd0;
    rec.lat_q  = coords_ok ? lat_q_nxt : QW'(0);
    rec.lon_ds = coords_ok ? lon_ds_nxt : 34'd0;
    rec.lon_q  = coords_ok ? lon_q_nxt : QW'(0);
    rec.hdop   = (k_out == rmcgga_pkg::KIND_GGA && comma_nxt >= 4'd8) ? hdop_nxt
                                                                       : rmcgga_pkg::HDOP_DEFAULT;
    rec.sats   = (k_out == rmcgga_pkg::KIND_GGA) ? sats_nxt : 8'd0;
    push       = take && line_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && line_end)) begin
      pos_r     <= 3'd0;
      kind_r    <= rmcgga_pkg::KIND_NONE;
      comma_r   <= 4'd0;
      cif_r     <= 5'd0;
      status_r  <= 8'd0;
      hemi_r    <= 2'd0;
      lat_ds_r  <= 30'd0;
      lat_min_r <= MW'(0);
      lat_q_r   <= QW'(0);
      lat_rem_r <= 6'd0;
      lon_ds_r  <= 34'd0;
      lon_min_r <= MW'(0);
      lon_q_r   <= QW'(0);
      lon_rem_r <= 6'd0;
      sats_r    <= 8'd0;
      hdop_r    <= 14'd0;
      dps_r     <= 1'b0;
      frac_r    <= 3'd0;
    end else if (take) begin
      pos_r     <= pos_nxt;
      kind_r    <= kind_nxt;
      comma_r   <= comma_nxt;
      cif_r     <= cif_nxt;
      status_r  <= status_nxt;
      hemi_r    <= hemi_nxt;
      lat_ds_r  <= lat_ds_nxt;
      lat_min_r <= lat_min_nxt;
      lat_q_r   <= lat_q_nxt;
      lat_rem_r <= lat_rem_nxt;
      lon_ds_r  <= lon_ds_nxt;
      lon_min_r <= lon_min_nxt;
      lon_q_r   <= lon_q_nxt;
      lon_rem_r <= lon_rem_nxt;
      sats_r    <= sats_nxt;
      hdop_r    <= hdop_nxt;
      dps_r     <= dps_nxt;
      frac_r    <= frac_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rmcgga_fifo.sv
// ----------------------------------------------------------------------------
// rmcgga_fifo
// Two-entry record queue between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rmcgga_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rmcgga_pkg::rec_t  wr_rec,
  input  logic              pop,
  output rmcgga_pkg::rec_t  rd_rec,
  output logic              not_empty,
  output logic              full
);

  rmcgga_pkg::rec_t  mem_r [2];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        cnt_r;

  assign not_empty = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign rd_rec    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rmcgga_back.sv
// ----------------------------------------------------------------------------
// rmcgga_back
// Output stage: sums degrees and minutes, saturates, applies hemisphere sign
// and holds the result until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rmcgga_back (
  input  logic               clk,
  input  logic               rst_n,
  input  rmcgga_pkg::rec_t   rec,
  input  logic               rec_valid,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_sentence_kind,
  output logic               out_has_fix,
  output logic signed [30:0] out_latitude,
  output logic signed [34:0] out_longitude,
  output logic [13:0]        out_hdop_tenths,
  output logic [7:0]         out_satellites
);

  localparam int unsigned MAGW = rmcgga_pkg::MAGW;

  logic              valid_r;
  logic [1:0]        kind_r;
  logic              fix_r;
  logic [30:0]       lat_r, lat_mag, lat_val;
  logic [34:0]       lon_r, lon_mag, lon_val;
  logic [13:0]       hdop_r;
  logic [7:0]        sats_r;
  logic [MAGW-1:0]   lat_sum, lon_sum;

  assign pop = rec_valid && (!valid_r || out_ready);

  always_comb begin
    lat_sum = MAGW'(rec.lat_ds) + MAGW'(rec.lat_q);
    lon_sum = MAGW'(rec.lon_ds) + MAGW'(rec.lon_q);
    lat_mag = (lat_sum > MAGW'(rmcgga_pkg::LAT_CAP)) ? rmcgga_pkg::LAT_CAP : 31'(lat_sum);
    lon_mag = (lon_sum > MAGW'(rmcgga_pkg::LON_CAP)) ? rmcgga_pkg::LON_CAP : 35'(lon_sum);
    lat_val = rec.south ? 31'd0 - lat_mag : lat_mag;
    lon_val = rec.west  ? 35'd0 - lon_mag : lon_mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r <= rec.kind;
      fix_r  <= rec.fix;
      lat_r  <= lat_val;
      lon_r  <= lon_val;
      hdop_r <= rec.hdop;
      sats_r <= rec.sats;
    end
  end

  assign out_valid         = valid_r;
  assign out_sentence_kind = kind_r;
  assign out_has_fix       = fix_r;
  assign out_latitude      = lat_r;
  assign out_longitude     = lon_r;
  assign out_hdop_tenths   = hdop_r;
  assign out_satellites    = sats_r;

endmodule

`default_nettype wire

>>> hw/rtl/nmea_rmc_gga_line_parser.sv
// ----------------------------------------------------------------------------
// nmea_rmc_gga_line_parser
// NMEA 0183 RMC/GGA sentence parser, one character per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one character per transaction; in_line_end marks
//   the last character of a line. Up to one character is taken every cycle.
//   Output channel (out_*): one transaction per line, issued for the
//   character that carries in_line_end: sentence kind, fix flag, signed
//   coordinates in 1e-7 degree, HDOP in tenths and satellite count.
//   The record of the final character enters the queue at the accepting
//   edge and moves to the output register once that register is free
//   (empty, or its result taken by the receiver).
//   Throughput when nothing stalls: one character per cycle and one result
//   per cycle; the minute-to-degree division by 60 is carried along digit by
//   digit in the parser, so the output stage only adds, saturates and signs.
//   Stall: a stalled receiver holds the output register; the two-entry
//   record queue keeps absorbing finished lines, and in_ready drops only
//   while that queue is full.
//   Reset: synchronous, active low; clears all line state, empties the
//   queue and drops out_valid. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_rmc_gga_line_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_char_byte,
  input  logic               in_line_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_sentence_kind,
  output logic               out_has_fix,
  output logic signed [30:0] out_latitude,
  output logic signed [34:0] out_longitude,
  output logic [13:0]        out_hdop_tenths,
  output logic [7:0]         out_satellites
);

  rmcgga_pkg::rec_t  wr_rec, rd_rec;
  logic              take, push, pop, not_empty, full;

  // Accept a character whenever the queue has room for a line record
  assign in_ready = !full;
  assign take     = in_valid && in_ready;

  rmcgga_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .char_byte (in_char_byte),
    .line_end  (in_line_end),
    .push      (push),
    .rec       (wr_rec)
  );

  rmcgga_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_rec    (wr_rec),
    .pop       (pop),
    .rd_rec    (rd_rec),
    .not_empty (not_empty),
    .full      (full)
  );

  rmcgga_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .rec               (rd_rec),
    .rec_valid         (not_empty),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sentence_kind (out_sentence_kind),
    .out_has_fix       (out_has_fix),
    .out_latitude      (out_latitude),
    .out_longitude     (out_longitude),
    .out_hdop_tenths   (out_hdop_tenths),
    .out_satellites    (out_satellites)
  );

endmodule

`default_nettype wire

>>> hw/rtl/rmcgga_checker.sv
// ----------------------------------------------------------------------------
// rmcgga_checker
// Port-level checks of the line parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rmcgga_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [7:0]         in_char_byte,
  input logic               in_line_end,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_sentence_kind,
  input logic               out_has_fix,
  input logic signed [30:0] out_latitude,
  input logic signed [34:0] out_longitude,
  input logic [13:0]        out_hdop_tenths,
  input logic [7:0]         out_satellites
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_latitude) &&
      $stable(out_longitude) && $stable(out_sentence_kind))
    else $error("stalled result changed");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sentence_kind == 2'd0 |-> !out_has_fix && out_latitude == 31'sd0 &&
      out_longitude == 35'sd0 && out_hdop_tenths == 14'd999 && out_satellites == 8'd0)
    else $error("unrecognized line with non-default fields");

  a_rmc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sentence_kind == 2'd1 |-> out_hdop_tenths == 14'd999 &&
      out_satellites == 8'd0)
    else $error("RMC result with GGA-only fields set");

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_latitude <= 31'sd999999999 && out_latitude >= -31'sd999999999)
    else $error("latitude out of range");

endmodule

bind nmea_rmc_gga_line_parser rmcgga_checker u_rmcgga_checker (.*);

`default_nettype wire

>>> test/nmea_line_checker.sv
// ----------------------------------------------------------------------------
// nmea_line_checker
// Watches the character and result channels of the RMC/GGA line parser,
// predicts the result of every finished line and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmea_line_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         in_char_byte,
  input  logic               in_line_end,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         out_sentence_kind,
  input  logic               out_has_fix,
  input  logic signed [30:0] out_latitude,
  input  logic signed [34:0] out_longitude,
  input  logic [13:0]        out_hdop_tenths,
  input  logic [7:0]         out_satellites,
  output int                 errors,
  output int                 pending_lines
);

  typedef struct packed {
    logic [1:0]  kind;
    logic        fix;
    logic [30:0] lat;
    logic [34:0] lon;
    logic [13:0] hdop;
    logic [7:0]  sats;
  } line_result_t;

  line_result_t expected_lines[$];

  int unsigned      pos, kind, commas, field_chars, status, hemi, sats, hdop, dot_seen, frac;
  longint unsigned  lat_deg, lat_min, lon_deg, lon_min;

  localparam longint unsigned MINUTE_CAP = 64'd999999999999;

  function automatic longint unsigned ten_to(input int unsigned n);
    longint unsigned v = 1;
    for (int i = 0; i < n; i++) v = v * 10;
    return v;
  endfunction

  task automatic clear_line();
    pos = 0; kind = rmcgga_pkg::KIND_NONE; commas = 0; field_chars = 0; status = 0;
    hemi = 0; sats = 0; hdop = 0; dot_seen = 0; frac = 0;
    lat_deg = 0; lat_min = 0; lon_deg = 0; lon_min = 0;
  endtask

  // Feed one character of a coordinate field into its degree/minute pair
  task automatic add_coord_char(inout longint unsigned deg, inout longint unsigned mins,
                                input int unsigned deg_len, input logic [7:0] ch);
    bit              dig;
    longint unsigned d;
    dig = ch >= rmcgga_pkg::CH_0 && ch <= rmcgga_pkg::CH_9;
    d = dig ? ch - rmcgga_pkg::CH_0 : 0;
    if (field_chars >= rmcgga_pkg::COORD_FIELD_CHARS) return;
    if (field_chars < deg_len) begin
      if (dig) deg = deg * 10 + d;
      return;
    end
    if (ch == rmcgga_pkg::CH_DOT) begin
      dot_seen = 1;
      return;
    end
    if (!dig) return;
    if (!dot_seen) begin
      if (mins > MINUTE_CAP / 10) mins = MINUTE_CAP;
      else mins = mins * 10 + d * ten_to(rmcgga_pkg::MINUTE_FRACTION_DIGITS);
    end else if (frac < rmcgga_pkg::MINUTE_FRACTION_DIGITS) begin
      frac++;
      mins += d * ten_to(rmcgga_pkg::MINUTE_FRACTION_DIGITS - frac);
    end
    if (mins > MINUTE_CAP) mins = MINUTE_CAP;
  endtask

  task automatic add_hdop_char(input logic [7:0] ch);
    bit dig;
    dig = ch >= rmcgga_pkg::CH_0 && ch <= rmcgga_pkg::CH_9;
    if (field_chars >= rmcgga_pkg::HDOP_FIELD_CHARS) return;
    if (ch == rmcgga_pkg::CH_DOT) begin
      dot_seen = 1;
      return;
    end
    if (!dig) return;
    if (!dot_seen) begin
      if (hdop > 999) hdop = 9999;
      else hdop = hdop * 10 + (ch - rmcgga_pkg::CH_0) * 10;
    end else if (frac == 0) begin
      frac = 1;
      hdop += ch - rmcgga_pkg::CH_0;
    end
    if (hdop > 9999) hdop = 9999;
  endtask

  function automatic longint unsigned coord_mag(input longint unsigned deg,
                                                input longint unsigned mins,
                                                input longint unsigned cap);
    longint unsigned m;
    m = deg * 64'd10000000
      + (mins * ten_to(7 - rmcgga_pkg::MINUTE_FRACTION_DIGITS)) / 60;
    return (m > cap) ? cap : m;
  endfunction

  // Advance the line state by one character; push a result on line end
  task automatic predict_char(input logic [7:0] b, input logic last);
    int unsigned  c, lat_field, k;
    bit           first;
    line_result_t r;
    longint unsigned m;
    if (pos == 0) begin
      kind = (b == rmcgga_pkg::CH_DOLLAR) ? rmcgga_pkg::KIND_PEND : rmcgga_pkg::KIND_NONE;
    end else if (pos == 3 && kind == rmcgga_pkg::KIND_PEND) begin
      kind = (b == rmcgga_pkg::CH_R) ? rmcgga_pkg::KIND_RMC :
             (b == rmcgga_pkg::CH_G) ? rmcgga_pkg::KIND_GGA : rmcgga_pkg::KIND_NONE;
    end else if (pos == 4) begin
      if ((kind == rmcgga_pkg::KIND_RMC && b != rmcgga_pkg::CH_M) ||
          (kind == rmcgga_pkg::KIND_GGA && b != rmcgga_pkg::CH_G))
        kind = rmcgga_pkg::KIND_NONE;
    end else if (pos == 5) begin
      if ((kind == rmcgga_pkg::KIND_RMC && b != rmcgga_pkg::CH_C) ||
          (kind == rmcgga_pkg::KIND_GGA && b != rmcgga_pkg::CH_A))
        kind = rmcgga_pkg::KIND_NONE;
    end
    if (pos < 7) pos++;

    if (b == rmcgga_pkg::CH_COMMA) begin
      if (commas < rmcgga_pkg::COMMA_MAX) begin
        commas++;
        field_chars = 0; dot_seen = 0; frac = 0;
        if (commas == 6 && kind == rmcgga_pkg::KIND_GGA) status = 0;
      end
    end else begin
      c = commas;
      first = field_chars == 0;
      if (c == 2 && first) status = b;
      if (kind == rmcgga_pkg::KIND_GGA && c == 6 && first) status = b;
      if (kind == rmcgga_pkg::KIND_RMC || kind == rmcgga_pkg::KIND_GGA) begin
        lat_field = (kind == rmcgga_pkg::KIND_RMC) ? 3 : 2;
        if (c == lat_field) add_coord_char(lat_deg, lat_min, 2, b);
        if (c == lat_field + 1 && first && b == rmcgga_pkg::CH_S) hemi |= 1;
        if (c == lat_field + 2) add_coord_char(lon_deg, lon_min, 3, b);
        if (c == lat_field + 3 && first && b == rmcgga_pkg::CH_W) hemi |= 2;
        if (kind == rmcgga_pkg::KIND_GGA && c == 7 &&
            field_chars < rmcgga_pkg::SATS_FIELD_CHARS &&
            b >= rmcgga_pkg::CH_0 && b <= rmcgga_pkg::CH_9)
          sats = (sats * 10 + (b - rmcgga_pkg::CH_0)) & 8'hFF;
        if (kind == rmcgga_pkg::KIND_GGA && c == 8) add_hdop_char(b);
      end
      if (field_chars < rmcgga_pkg::CIF_MAX) field_chars++;
    end

    if (!last) return;
    k = (pos >= 6 && (kind == rmcgga_pkg::KIND_RMC || kind == rmcgga_pkg::KIND_GGA))
      ? kind : rmcgga_pkg::KIND_NONE;
    r = '0;
    r.kind = 2'(k);
    r.hdop = rmcgga_pkg::HDOP_DEFAULT;
    if (k == rmcgga_pkg::KIND_RMC) r.fix = commas >= 2 && status == rmcgga_pkg::CH_A;
    if (k == rmcgga_pkg::KIND_GGA)
      r.fix = commas >= 6 && (status == rmcgga_pkg::CH_1 || status == rmcgga_pkg::CH_2);
    if (k != rmcgga_pkg::KIND_NONE) begin
      lat_field = (k == rmcgga_pkg::KIND_RMC) ? 3 : 2;
      if (commas >= lat_field + 3) begin
        m = coord_mag(lat_deg, lat_min, rmcgga_pkg::LAT_CAP);
        r.lat = (hemi & 1) ? 31'(-m) : 31'(m);
        m = coord_mag(lon_deg, lon_min, rmcgga_pkg::LON_CAP);
        r.lon = (hemi & 2) ? 35'(-m) : 35'(m);
      end
    end
    if (k == rmcgga_pkg::KIND_GGA) begin
      if (commas >= 8) r.hdop = 14'(hdop);
      r.sats = 8'(sats);
    end
    expected_lines.push_back(r);
    clear_line();
  endtask

  always @(posedge clk) begin
    line_result_t want;
    if (!rst_n) begin
      clear_line();
      expected_lines.delete();
      errors <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_lines.size() == 0) begin
          $display("%0t: result with no line pending: kind %0d", $time, out_sentence_kind);
          errors <= errors + 1;
        end else begin
          want = expected_lines.pop_front();
          if (want.kind !== out_sentence_kind || want.fix !== out_has_fix ||
              want.lat !== out_latitude || want.lon !== out_longitude ||
              want.hdop !== out_hdop_tenths || want.sats !== out_satellites) begin
            $display("%0t: mismatch exp kind %0d fix %0d lat %0d lon %0d hdop %0d sats %0d",
                     $time, want.kind, want.fix, $signed(want.lat), $signed(want.lon),
                     want.hdop, want.sats);
            $display("%0t:          got kind %0d fix %0d lat %0d lon %0d hdop %0d sats %0d",
                     $time, out_sentence_kind, out_has_fix, out_latitude, out_longitude,
                     out_hdop_tenths, out_satellites);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && in_ready) predict_char(in_char_byte, in_line_end);
    end
    pending_lines <= expected_lines.size();
  end

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives NMEA lines (well-formed RMC/GGA with random content, broken lines and
// noise) into the parser under varied sender gaps and receiver stalls; the
// checker predicts and compares, this top gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_char_byte;
  logic               in_line_end;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_sentence_kind;
  logic               out_has_fix;
  logic signed [30:0] out_latitude;
  logic signed [34:0] out_longitude;
  logic [13:0]        out_hdop_tenths;
  logic [7:0]         out_satellites;
  int                 errors;
  int                 pending_lines;

  // Idling phase: 0 none, 1 sender idles, 2 receiver stalls, 3 both
  int  phase;
  bit  hold_off;      // long receiver hold-off in progress
  int  idle_cycles;
  localparam int WATCHDOG_LIMIT = 20000;

  nmea_rmc_gga_line_parser dut (.*);

  nmea_line_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls per phase, or a counted long hold-off
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_off) out_ready <= 1'b0;
    else if (phase == 2 || phase == 3) out_ready <= ($urandom_range(99) >= 84);
    else out_ready <= 1'b1;
  end

  // Watchdog: count cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Offer one character; hold it until accepted
  task automatic send_char(input logic [7:0] ch, input logic last);
    if (phase == 1 || phase == 3) begin
      while ($urandom_range(99) < 84) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    in_char_byte <= ch;
    in_line_end  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_text(input string s, input bit ends_line);
    for (int i = 0; i < s.len(); i++) send_char(s[i], ends_line && i == s.len() - 1);
  endtask

  function automatic string digits(input int n);
    string s = "";
    for (int i = 0; i < n; i++)
      s = {s, string'(8'(rmcgga_pkg::CH_0 + $urandom_range(9)))};
    return s;
  endfunction

  // Random numeric field with occasional junk and extra dots
  function automatic string random_field(input int int_len);
    string s;
    s = digits(int_len);
    if ($urandom_range(3) != 0) s = {s, ".", digits($urandom_range(9))};
    if ($urandom_range(7) == 0) s = {s, ".", digits($urandom_range(3))};
    if ($urandom_range(9) == 0) s = {"-", s, " "};
    if ($urandom_range(11) == 0) s = {s, digits($urandom_range(20))};
    if ($urandom_range(15) == 0) s = "";
    return s;
  endfunction

  function automatic string talker();
    return {string'(8'($urandom_range(65, 90))), string'(8'($urandom_range(65, 90)))};
  endfunction

  function automatic string random_rmc();
    return {"$", talker(), "RMC,", digits(6), ".00,",
            ($urandom_range(2) != 0) ? "A" : "V", ",", random_field(4), ",",
            ($urandom_range(1) != 0) ? "S" : "N", ",", random_field(5), ",",
            ($urandom_range(1) != 0) ? "W" : "E", ",0.5,54.7,191194,020.3,E"};
  endfunction

  function automatic string random_gga();
    string fixc;
    fixc = string'(8'(rmcgga_pkg::CH_0 + $urandom_range(3)));
    return {"$", talker(), "GGA,", digits(6), ",", random_field(4), ",",
            ($urandom_range(1) != 0) ? "S" : "N", ",", random_field(5), ",",
            ($urandom_range(1) != 0) ? "W" : "E", ",", fixc, ",",
            digits($urandom_range(9)), ",", random_field($urandom_range(1, 5)),
            ",545.4,M,46.9,M,,*47"};
  endfunction

  // Random line: mostly well formed, some cut short or pure noise
  task automatic send_random_line();
    string s;
    int    r;
    r = $urandom_range(99);
    if (r < 40) s = random_rmc();
    else if (r < 80) s = random_gga();
    else if (r < 90) begin
      s = ($urandom_range(1) != 0) ? random_rmc() : random_gga();
      s = s.substr(0, $urandom_range(s.len() - 1));
    end else begin
      s = "";
      for (int i = $urandom_range(1, 30); i > 0; i--)
        s = {s, string'(8'($urandom_range(0, 255)))};
    end
    send_text(s, 1'b1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_lines != 0 || out_valid) @(posedge clk);
  endtask

  initial begin
    in_valid     = 1'b0;
    in_char_byte = 8'h00;
    in_line_end  = 1'b0;
    rst_n        = 1'b0;
    phase        = 0;
    hold_off     = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines: extremes, both kinds, short and broken lines
    send_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W", 1);
    send_text("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47", 1);
    send_text("$GNGGA,0,9999.999999999,S,99999.9999999999,W,2,99999999999,99999.9", 1);
    send_text("$XXRMC,0,A,9999.99999999999999999,S,99999.999999999,W", 1);
    send_text("$GPRMC,,V,,,,,,", 1);
    send_text("$GPGGA,1,-48 07.0x38,N,+011.31.00,E,0,-1 2,1..5", 1);
    send_text("$GPGGA,1,,,,,6", 1);
    send_text("$GPGGA,1,2,3,4,5,1,7", 1);
    send_text(",,,,,,,,,,,,,,,,,,,,", 1);
    send_text("$GPRM", 1);
    send_text("$", 1);
    send_char(8'hFF, 1);
    send_char(8'h00, 1);
    send_text("GPRMC,1,A,1,N,1,E", 1);
    send_text("$GPXMC,1,A", 1);
    send_text("$GPRMX,1,A", 1);
    send_text("$GPGGX,1", 1);
    send_text("$GPGXA,1", 1);
    send_text({"$GPRMC", 8'h00, ",A"}, 1);
    wait_drained();

    // Random lines across all idling phases, with a no-idle stretch first
    for (int p = 0; p < 4; p++) begin
      phase = p;
      send_random_line();
    end

    // Long receiver hold-off while lines keep arriving
    phase = 0;
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int n = 0; n < 4; n++) send_random_line();
      end
    join
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      phase = p;
      send_random_line();
    end
    wait_drained();

    in_valid <= 1'b0;
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
